@@ design/frame_ring_drop_oldest_assert.svh @@
// assertion macros for the frame ring queue
// expects clk and rst_n in the scope of use
`ifndef FRAME_RING_DROP_OLDEST_ASSERT_SVH
`define FRAME_RING_DROP_OLDEST_ASSERT_SVH

`ifndef SYNTH
`define FRDO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frdo assertion failed");
`define FRDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frdo assertion failed");
`else
`define FRDO_ASSERT_NOW(label, ante, cons)
`define FRDO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/frdo_pkg.sv @@
// shared widths and codes for the frame ring queue
// no dependencies
package frdo_pkg;

  localparam int ACT_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 9;
  localparam int CNT_W   = 10;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int SHED_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONSUME = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 7'd8;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 7'd64;

endpackage

@@ design/frdo_in_if.sv @@
// request channel of the frame ring queue
// depends on frdo_pkg
interface frdo_in_if;
  logic                          valid;
  logic                          ready;
  logic [frdo_pkg::ACT_W-1:0]    action;
  logic [frdo_pkg::BYTE_W-1:0]   data_byte;
  logic                          byte_last;
  logic [frdo_pkg::IDX_W-1:0]    frame_index;
  logic [frdo_pkg::CNT_W-1:0]    consume_count;

  modport source (output valid, action, data_byte, byte_last, frame_index, consume_count,
                  input ready);
  modport sink (input valid, action, data_byte, byte_last, frame_index, consume_count,
                output ready);
endinterface

@@ design/frdo_out_if.sv @@
// result channel of the frame ring queue
// depends on frdo_pkg
interface frdo_out_if;
  logic                          valid;
  logic                          ready;
  logic [frdo_pkg::STAT_W-1:0]   status;
  logic                          dropped_oldest;
  logic [frdo_pkg::BYTE_W-1:0]   out_byte;
  logic [frdo_pkg::LEN_W-1:0]    out_length;
  logic                          last_of_run;
  logic [frdo_pkg::CNT_W-1:0]    queue_depth;
  logic [frdo_pkg::SHED_W-1:0]   shed_count;

  modport source (output valid, status, dropped_oldest, out_byte, out_length, last_of_run,
                  queue_depth, shed_count, input ready);
  modport sink (input valid, status, dropped_oldest, out_byte, out_length, last_of_run,
                queue_depth, shed_count, output ready);
endinterface

@@ design/frdo_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module frdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/frame_ring_drop_oldest.sv @@
// frame queue with drop-oldest on overflow; commit, consume and out-of-range read: result
// registered in the cycle after the transaction is taken, one push byte per cycle while the
// result register drains; read of a stored frame: length ram read, frame ram read, then one
// byte per cycle while the result register drains; no new transaction while a read streams
// synchronous active-low reset clears pointers, count, shed counter and the partial frame,
// sets min_length 8 and max_length 64; frame and length rams are not cleared
module frame_ring_drop_oldest #(
  parameter int SLOTS     = 512,
  parameter int MAX_FRAME = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [frdo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frdo_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  frdo_in_if.sink                             in_chan,
  frdo_out_if.source                          out_chan
);
  localparam int RING   = SLOTS + 1;
  localparam int SW     = $clog2(RING);
  localparam int PW     = $clog2(MAX_FRAME);
  localparam int FAW    = SW + PW;
  localparam int FDEPTH = RING * (2 ** PW);
  localparam int XW     = ((SW > frdo_pkg::CNT_W) ? SW : frdo_pkg::CNT_W) + 1;
  localparam int LW     = frdo_pkg::LEN_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LEN    = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [SW-1:0]                    head_r, head_nxt;
  logic [SW-1:0]                    tail_r, tail_nxt;
  logic [SW-1:0]                    count_r, count_nxt;
  logic [frdo_pkg::SHED_W-1:0]      shed_r, shed_nxt;
  logic [LW-1:0]                    wpos_r, wpos_nxt;
  logic                             overlong_r, overlong_nxt;
  logic [LW-1:0]                    min_r, max_r;
  logic [SW-1:0]                    rd_slot_r, rd_slot_nxt;
  logic [LW-1:0]                    rd_pos_r, rd_pos_nxt;
  logic [LW-1:0]                    rd_len_r, rd_len_nxt;

  logic                             ov_r, ov_nxt;
  logic [frdo_pkg::STAT_W-1:0]      o_status_r, o_status_nxt;
  logic                             o_drop_r, o_drop_nxt;
  logic [frdo_pkg::BYTE_W-1:0]      o_byte_r, o_byte_nxt;
  logic [LW-1:0]                    o_len_r, o_len_nxt;
  logic                             o_last_r, o_last_nxt;
  logic [frdo_pkg::CNT_W-1:0]       o_depth_r, o_depth_nxt;
  logic [frdo_pkg::SHED_W-1:0]      o_shed_r, o_shed_nxt;

  logic                             can_load, in_fire;
  logic                             fr_we, fr_re, len_we, len_re;
  logic [FAW-1:0]                   fr_waddr, fr_raddr;
  logic [frdo_pkg::BYTE_W-1:0]      fr_rdata;
  logic [SW-1:0]                    len_raddr;
  logic [LW-1:0]                    len_wdata, len_rdata, len_clip;
  logic                             wrote, ovl_now, len_ok;
  logic [LW-1:0]                    flen;
  logic [XW-1:0]                    idx_x, cnt_x, sum_x, n_x, depth_x;
  logic [PW-1:0]                    rpos;

  assign can_load       = !ov_r || out_chan.ready;
  assign in_chan.ready  = rst_n && (state_r == S_IDLE) && can_load;
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign wrote   = (wpos_r < LW'(MAX_FRAME));
  assign ovl_now = overlong_r || !wrote;
  assign flen    = wrote ? (wpos_r + LW'(1)) : wpos_r;
  assign len_ok  = !ovl_now && (flen >= min_r) && (flen <= max_r);

  assign idx_x    = XW'(in_chan.frame_index);
  assign cnt_x    = XW'(count_r);
  assign len_clip = (len_rdata > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : len_rdata;
  assign rpos     = (state_r == S_LEN) ? '0 : rd_pos_r[PW-1:0];

  assign fr_we     = in_fire && (in_chan.action == frdo_pkg::ACT_PUSH) && wrote;
  assign fr_waddr  = {head_r, wpos_r[PW-1:0]};
  assign fr_raddr  = {rd_slot_r, rpos};
  assign len_wdata = flen;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    shed_nxt     = shed_r;
    wpos_nxt     = wpos_r;
    overlong_nxt = overlong_r;
    rd_slot_nxt  = rd_slot_r;
    rd_pos_nxt   = rd_pos_r;
    rd_len_nxt   = rd_len_r;
    ov_nxt       = ov_r && !out_chan.ready;
    o_status_nxt = o_status_r;
    o_drop_nxt   = o_drop_r;
    o_byte_nxt   = o_byte_r;
    o_len_nxt    = o_len_r;
    o_last_nxt   = o_last_r;
    o_depth_nxt  = o_depth_r;
    o_shed_nxt   = o_shed_r;
    len_we       = 1'b0;
    len_re       = 1'b0;
    len_raddr    = '0;
    fr_re        = 1'b0;
    sum_x        = '0;
    n_x          = '0;
    depth_x      = cnt_x;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.action)
            frdo_pkg::ACT_PUSH: begin
              if (wrote) begin
                wpos_nxt = wpos_r + LW'(1);
              end else begin
                overlong_nxt = 1'b1;
              end
              if (in_chan.byte_last) begin
                wpos_nxt     = '0;
                overlong_nxt = 1'b0;
                ov_nxt       = 1'b1;
                o_byte_nxt   = '0;
                o_last_nxt   = 1'b1;
                o_drop_nxt   = 1'b0;
                if (!len_ok) begin
                  o_status_nxt = frdo_pkg::ST_REJECT;
                  o_len_nxt    = '0;
                end else begin
                  o_status_nxt = frdo_pkg::ST_OK;
                  o_len_nxt    = flen;
                  len_we       = 1'b1;
                  head_nxt     = (head_r == SW'(RING - 1)) ? '0 : head_r + SW'(1);
                  if (count_r == SW'(SLOTS)) begin
                    tail_nxt   = (tail_r == SW'(RING - 1)) ? '0 : tail_r + SW'(1);
                    o_drop_nxt = 1'b1;
                    if (shed_r != '1) begin
                      shed_nxt = shed_r + 32'd1;
                    end
                  end else begin
                    count_nxt = count_r + SW'(1);
                  end
                end
                depth_x     = XW'(count_nxt);
                o_depth_nxt = depth_x[frdo_pkg::CNT_W-1:0];
                o_shed_nxt  = shed_nxt;
              end
            end
            frdo_pkg::ACT_READ: begin
              if (idx_x >= cnt_x) begin
                ov_nxt       = 1'b1;
                o_status_nxt = frdo_pkg::ST_NO_FRAME;
                o_drop_nxt   = 1'b0;
                o_byte_nxt   = '0;
                o_len_nxt    = '0;
                o_last_nxt   = 1'b1;
                o_depth_nxt  = depth_x[frdo_pkg::CNT_W-1:0];
                o_shed_nxt   = shed_r;
              end else begin
                sum_x       = XW'(tail_r) + idx_x;
                if (sum_x >= XW'(RING)) begin
                  sum_x = sum_x - XW'(RING);
                end
                rd_slot_nxt = sum_x[SW-1:0];
                len_re      = 1'b1;
                len_raddr   = sum_x[SW-1:0];
                state_nxt   = S_LEN;
              end
            end
            frdo_pkg::ACT_CONSUME: begin
              n_x = XW'(in_chan.consume_count);
              if (n_x > cnt_x) begin
                n_x = cnt_x;
              end
              sum_x = XW'(tail_r) + n_x;
              if (sum_x >= XW'(RING)) begin
                sum_x = sum_x - XW'(RING);
              end
              tail_nxt     = sum_x[SW-1:0];
              depth_x      = cnt_x - n_x;
              count_nxt    = depth_x[SW-1:0];
              ov_nxt       = 1'b1;
              o_status_nxt = frdo_pkg::ST_OK;
              o_drop_nxt   = 1'b0;
              o_byte_nxt   = '0;
              o_len_nxt    = '0;
              o_last_nxt   = 1'b1;
              o_depth_nxt  = depth_x[frdo_pkg::CNT_W-1:0];
              o_shed_nxt   = shed_r;
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        rd_len_nxt = len_clip;
        if (len_clip == '0) begin
          if (can_load) begin
            ov_nxt       = 1'b1;
            o_status_nxt = frdo_pkg::ST_OK;
            o_drop_nxt   = 1'b0;
            o_byte_nxt   = '0;
            o_len_nxt    = '0;
            o_last_nxt   = 1'b1;
            o_depth_nxt  = depth_x[frdo_pkg::CNT_W-1:0];
            o_shed_nxt   = shed_r;
            state_nxt    = S_IDLE;
          end
        end else begin
          fr_re      = 1'b1;
          rd_pos_nxt = LW'(1);
          state_nxt  = S_STREAM;
        end
      end
      S_STREAM: begin
        if (can_load) begin
          ov_nxt       = 1'b1;
          o_status_nxt = frdo_pkg::ST_OK;
          o_drop_nxt   = 1'b0;
          o_byte_nxt   = fr_rdata;
          o_len_nxt    = rd_len_r;
          o_last_nxt   = (rd_pos_r == rd_len_r);
          o_depth_nxt  = depth_x[frdo_pkg::CNT_W-1:0];
          o_shed_nxt   = shed_r;
          if (rd_pos_r == rd_len_r) begin
            state_nxt = S_IDLE;
          end else begin
            fr_re      = 1'b1;
            rd_pos_nxt = rd_pos_r + LW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      shed_r     <= '0;
      wpos_r     <= '0;
      overlong_r <= 1'b0;
      ov_r       <= 1'b0;
      min_r      <= frdo_pkg::MIN_LENGTH_RST;
      max_r      <= frdo_pkg::MAX_LENGTH_RST;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      shed_r     <= shed_nxt;
      wpos_r     <= wpos_nxt;
      overlong_r <= overlong_nxt;
      ov_r       <= ov_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          frdo_pkg::REG_MIN_LENGTH: min_r <= cfg_wr_data;
          frdo_pkg::REG_MAX_LENGTH: max_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r  <= rd_slot_nxt;
    rd_pos_r   <= rd_pos_nxt;
    rd_len_r   <= rd_len_nxt;
    o_status_r <= o_status_nxt;
    o_drop_r   <= o_drop_nxt;
    o_byte_r   <= o_byte_nxt;
    o_len_r    <= o_len_nxt;
    o_last_r   <= o_last_nxt;
    o_depth_r  <= o_depth_nxt;
    o_shed_r   <= o_shed_nxt;
  end

  frdo_ram #(
    .WIDTH (frdo_pkg::BYTE_W),
    .DEPTH (FDEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (in_chan.data_byte),
    .re    (fr_re),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  frdo_ram #(
    .WIDTH (LW),
    .DEPTH (RING)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (head_r),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  assign out_chan.valid          = ov_r;
  assign out_chan.status         = o_status_r;
  assign out_chan.dropped_oldest = o_drop_r;
  assign out_chan.out_byte       = o_byte_r;
  assign out_chan.out_length     = o_len_r;
  assign out_chan.last_of_run    = o_last_r;
  assign out_chan.queue_depth    = o_depth_r;
  assign out_chan.shed_count     = o_shed_r;

`include "frame_ring_drop_oldest_assert.svh"

  `FRDO_ASSERT_NOW(a_count_max, 1'b1, count_r <= SW'(SLOTS))
  `FRDO_ASSERT_NOW(a_busy_no_ready, state_r != S_IDLE, !in_chan.ready)
  `FRDO_ASSERT_NEXT(a_shed_monotonic, 1'b1, shed_r >= $past(shed_r))
  `FRDO_ASSERT_NOW(a_stream_pos, state_r == S_STREAM, rd_pos_r != '0 && rd_pos_r <= rd_len_r)

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for frame_ring_drop_oldest: directed and random push, read and consume
// traffic with random idling, predicted per transaction by a scoreboard class
// depends on frdo_pkg, frdo_in_if, frdo_out_if and the frame_ring_drop_oldest rtl
module tb_top;
  localparam int ACT_W      = frdo_pkg::ACT_W;
  localparam int BYTE_W     = frdo_pkg::BYTE_W;
  localparam int IDX_W      = frdo_pkg::IDX_W;
  localparam int CNT_W      = frdo_pkg::CNT_W;
  localparam int LEN_W      = frdo_pkg::LEN_W;
  localparam int STAT_W     = frdo_pkg::STAT_W;
  localparam int SHED_W     = frdo_pkg::SHED_W;
  localparam int CFG_IDX_W  = frdo_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = frdo_pkg::CFG_DATA_W;

  localparam int SLOTS_N = 512;
  localparam int FRAME_N = 64;
  localparam int RING_N = SLOTS_N + 1;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_last;
    logic [IDX_W-1:0]  frame_index;
    logic [CNT_W-1:0]  consume_count;
  } frame_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              dropped_oldest;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  out_length;
    logic              last_of_run;
    logic [CNT_W-1:0]  queue_depth;
    logic [SHED_W-1:0] shed_count;
  } frame_res_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] frame_mem [RING_N][FRAME_N];
    logic [LEN_W-1:0]  len_mem [RING_N];
    int unsigned       head, tail, held, wr_pos;
    logic [SHED_W-1:0] shed;
    bit                overlong;
    logic [LEN_W-1:0]  min_len, max_len;
    frame_res_t        pending_q [$];
    int unsigned       errors;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      wr_pos = 0;
      shed = '0;
      overlong = 0;
      min_len = frdo_pkg::MIN_LENGTH_RST;
      max_len = frdo_pkg::MAX_LENGTH_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == frdo_pkg::REG_MIN_LENGTH) min_len = val;
      else if (idx == frdo_pkg::REG_MAX_LENGTH) max_len = val;
    endfunction

    function int unsigned depth();
      return held;
    endfunction

    function int unsigned waiting();
      return pending_q.size();
    endfunction

    function void add_result(logic [STAT_W-1:0] st, logic dropped, logic [BYTE_W-1:0] data,
                             int unsigned len, logic last);
      frame_res_t res;
      res.status = st;
      res.dropped_oldest = dropped;
      res.out_byte = data;
      res.out_length = LEN_W'(len);
      res.last_of_run = last;
      res.queue_depth = CNT_W'(held);
      res.shed_count = shed;
      pending_q.push_back(res);
    endfunction

    function void note_input(frame_req_t r);
      int unsigned len, slot, n;
      bit ok, dropped;
      case (r.action)
        frdo_pkg::ACT_PUSH: begin
          if (wr_pos < FRAME_N) begin
            frame_mem[head][wr_pos] = r.data_byte;
            wr_pos++;
          end else begin
            overlong = 1;
          end
          if (r.byte_last) begin
            len = wr_pos;
            ok = !overlong && len >= min_len && len <= max_len;
            wr_pos = 0;
            overlong = 0;
            if (!ok) begin
              add_result(frdo_pkg::ST_REJECT, 1'b0, '0, 0, 1'b1);
            end else begin
              dropped = 0;
              // full ring: the oldest frame makes room
              if (held >= SLOTS_N) begin
                tail = (tail + 1) % RING_N;
                held--;
                if (shed != '1) shed++;
                dropped = 1;
              end
              len_mem[head] = LEN_W'(len);
              head = (head + 1) % RING_N;
              held++;
              add_result(frdo_pkg::ST_OK, dropped, '0, len, 1'b1);
            end
          end
        end
        frdo_pkg::ACT_READ: begin
          if (r.frame_index >= held) begin
            add_result(frdo_pkg::ST_NO_FRAME, 1'b0, '0, 0, 1'b1);
          end else begin
            slot = (tail + r.frame_index) % RING_N;
            len = 32'(len_mem[slot]);
            if (len > FRAME_N) len = FRAME_N;
            if (len == 0) add_result(frdo_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
            for (int unsigned i = 0; i < len; i++)
              add_result(frdo_pkg::ST_OK, 1'b0, frame_mem[slot][i], len, i + 1 == len);
          end
        end
        frdo_pkg::ACT_CONSUME: begin
          n = 32'(r.consume_count);
          if (n > held) n = held;
          tail = (tail + n) % RING_N;
          held -= n;
          add_result(frdo_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 40)
        $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $time);
    endtask

    task check_result(frame_res_t got);
      frame_res_t want;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.dropped_oldest !== want.dropped_oldest)
        report("dropped_oldest", want.dropped_oldest, got.dropped_oldest);
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.out_length !== want.out_length)
        report("out_length", want.out_length, got.out_length);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
      if (got.queue_depth !== want.queue_depth)
        report("queue_depth", want.queue_depth, got.queue_depth);
      if (got.shed_count !== want.shed_count)
        report("shed_count", want.shed_count, got.shed_count);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  frdo_in_if  in_chan ();
  frdo_out_if out_chan ();

  frame_ring_drop_oldest #(
    .SLOTS     (SLOTS_N),
    .MAX_FRAME (FRAME_N)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  frame_scoreboard sb = new();
  frame_res_t      mon_res;
  int unsigned     idle_pct, stall_pct, items_sent, quiet_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      mon_res.status = out_chan.status;
      mon_res.dropped_oldest = out_chan.dropped_oldest;
      mon_res.out_byte = out_chan.out_byte;
      mon_res.out_length = out_chan.out_length;
      mon_res.last_of_run = out_chan.last_of_run;
      mon_res.queue_depth = out_chan.queue_depth;
      mon_res.shed_count = out_chan.shed_count;
      sb.check_result(mon_res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic frame_req_t rand_req(logic [ACT_W-1:0] act);
    frame_req_t r;
    r.action = act;
    r.data_byte = BYTE_W'($urandom);
    r.byte_last = 1'($urandom);
    r.frame_index = IDX_W'($urandom);
    r.consume_count = CNT_W'($urandom);
    return r;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return $urandom_range(12, 1);
    if (p < 96) return $urandom_range(FRAME_N, 13);
    return $urandom_range(FRAME_N + 4, FRAME_N + 1);
  endfunction

  task automatic send(input frame_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.action = r.action;
    in_chan.data_byte = r.data_byte;
    in_chan.byte_last = r.byte_last;
    in_chan.frame_index = r.frame_index;
    in_chan.consume_count = r.consume_count;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sb.note_input(r);
    if (r.action != ACT_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic push_frame(input int unsigned len, input bit extremes);
    frame_req_t r;
    for (int unsigned i = 0; i < len; i++) begin
      r = rand_req(frdo_pkg::ACT_PUSH);
      if (extremes) r.data_byte = i[0] ? 8'hFF : 8'h00;
      r.byte_last = (i + 1 == len);
      send(r);
    end
  endtask

  task automatic read_frame(input int unsigned idx);
    frame_req_t r;
    r = rand_req(frdo_pkg::ACT_READ);
    r.frame_index = IDX_W'(idx);
    send(r);
  endtask

  task automatic consume(input int unsigned n);
    frame_req_t r;
    r = rand_req(frdo_pkg::ACT_CONSUME);
    r.consume_count = CNT_W'(n);
    send(r);
  endtask

  task automatic drain();
    in_chan.valid = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (8) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = val;
    @(negedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_lengths(input int unsigned lo, input int unsigned hi);
    write_reg(frdo_pkg::REG_MIN_LENGTH, CFG_DATA_W'(lo));
    write_reg(frdo_pkg::REG_MAX_LENGTH, CFG_DATA_W'(hi));
  endtask

  task automatic run_mix(input int unsigned budget);
    int unsigned stop_at, pick, depth;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      depth = sb.depth();
      if (pick < 50) push_frame(pick_len(), 1'b0);
      else if (pick < 75)
        read_frame((depth != 0 && $urandom_range(99) < 85) ? $urandom_range(depth - 1)
                                                           : $urandom_range(511));
      else if (pick < 90)
        consume(($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(SLOTS_N));
      else if (pick < 96) send(rand_req(ACT_NONE));
      else drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = frdo_pkg::REG_MIN_LENGTH;
    cfg_wr_data = '0;
    in_chan.valid = 1'b0;
    in_chan.action = frdo_pkg::ACT_PUSH;
    in_chan.data_byte = '0;
    in_chan.byte_last = 1'b0;
    in_chan.frame_index = '0;
    in_chan.consume_count = '0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queue, short reject, minimum frame, reads past depth
    read_frame(0);
    consume(4);
    send(rand_req(ACT_NONE));
    push_frame(1, 1'b1);
    push_frame(8, 1'b1);
    read_frame(0);
    read_frame(1);
    read_frame(511);
    consume(SLOTS_N);
    read_frame(0);
    drain();

    run_mix(100);

    set_lengths(1, 16);
    idle_pct = 45;
    run_mix(80);

    set_lengths(3, 63);
    idle_pct = 0;
    stall_pct = 45;
    run_mix(80);

    // min above max rejects everything
    set_lengths(40, 20);
    idle_pct = 28;
    stall_pct = 28;
    run_mix(40);

    // fill the ring past full so commits shed the oldest frame
    set_lengths(1, FRAME_N);
    consume(SLOTS_N);
    for (int k = 0; k < SLOTS_N + 24; k++) begin
      push_frame(1, 1'b0);
      if (k % 32 == 31) read_frame(sb.depth() - 1 - $urandom_range(3));
      if (k == SLOTS_N / 2) drain();
    end
    repeat (6) read_frame($urandom_range(SLOTS_N - 1));
    consume(1);
    read_frame(SLOTS_N - 1);
    push_frame(1, 1'b0);
    push_frame(1, 1'b0);
    read_frame(SLOTS_N - 1);
    consume(SLOTS_N);

    // exact length only; an overlong frame is rejected even though 64 bytes were kept
    set_lengths(FRAME_N, FRAME_N);
    idle_pct = 0;
    stall_pct = 45;
    push_frame(FRAME_N, 1'b0);
    push_frame(FRAME_N + 1, 1'b0);
    read_frame(0);
    read_frame(1);

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
